FILE: src/mmfs_pkg.sv
// Shared constants and types for the max-min fair share allocator.
package mmfs_pkg;
  localparam int MaxPeople = 64;
  localparam int IdxW = $clog2(MaxPeople);
  localparam int CntW = $clog2(MaxPeople + 1);
  localparam int AmtW = 32;
  localparam int KeyW = AmtW + IdxW;

  typedef logic [AmtW-1:0] amt_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic done;
    amt_t quo;
    logic rem_nz;
  } div_res_t;
endpackage

FILE: src/max_min_fair_share_allocator.sv
// Max-min fair share allocator: cap loading, selection sequencer and result output.
// Sequence: caps load one per cycle; after the last cap, each selection pass takes
// one scan of the caps plus a serial division and update, and a case takes n
// passes, or n+1 when the capped phase ends early; then the results are output,
// each held until the receiver takes it.
// Throughput: one case at a time; set by the cap scan and the shared divider.
// Reset: rst_ni clears control state, the total and the count; stores are not cleared.
module max_min_fair_share_allocator import mmfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] amount_i,
  input  logic        last_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] share_o,
  output logic [5:0]  person_index_o,
  output logic        impossible_o,
  output logic        last_result_o
);
  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StDec  = 3'd3;
  localparam logic [2:0] StOrd  = 3'd4;
  localparam logic [2:0] StOwt  = 3'd5;
  localparam logic [2:0] StHold = 3'd6;

  logic [2:0] state_q, state_d;
  cnt_t cnt_q, cnt_d, n_q, n_d, i_q, i_d, k_q, k_d;
  amt_t rem_q, rem_d, ceil_q, ceil_d;
  amt_t total_q, total_d;
  logic phase_b_q, phase_b_d, have_prev_q, have_prev_d, found_q, found_d;
  key_t prev_q, prev_d, brk_q, brk_d, best_q, best_d;
  amt_t best_cap_q, best_cap_d;
  idx_t best_idx_q, best_idx_d;
  logic rd_vld_q, rd_vld_d;
  idx_t rd_idx_q;
  logic out_valid_q, out_valid_d;
  amt_t out_share_q, out_share_d;
  idx_t out_idx_q, out_idx_d;
  logic out_imp_q, out_imp_d, out_last_q, out_last_d;

  amt_t cap_mem [MaxPeople];
  amt_t share_mem [MaxPeople];
  amt_t cap_rd_q, share_rd_q;

  logic in_acc, cap_we, sh_we, div_start, issue, elig;
  amt_t sh_wd;
  key_t key_a, key_b, key_sel;
  div_res_t div_res;

  assign in_ready_o = state_q == StLoad;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cap_we     = in_acc && func_i && (cnt_q < CntW'(MaxPeople));
  assign issue      = (state_q == StScan) && (k_q < n_q);

  assign key_a   = {cap_rd_q, rd_idx_q};
  assign key_b   = {~cap_rd_q, rd_idx_q};
  assign key_sel = phase_b_q ? key_b : key_a;
  assign elig    = phase_b_q ? ((key_a >= brk_q) && (!have_prev_q || key_b > prev_q))
                             : (!have_prev_q || key_a > prev_q);

  mmfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (rem_q),
    .den_i   (CntW'(n_q - i_q)),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_mem[cnt_q[IdxW-1:0]] <= amount_i;
    end
    cap_rd_q <= cap_mem[k_q[IdxW-1:0]];
    rd_idx_q <= k_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (sh_we) begin
      share_mem[best_idx_q] <= sh_wd;
    end
    share_rd_q <= share_mem[k_q[IdxW-1:0]];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    k_d         = k_q;
    rem_d       = rem_q;
    total_d     = total_q;
    ceil_d      = ceil_q;
    phase_b_d   = phase_b_q;
    have_prev_d = have_prev_q;
    found_d     = found_q;
    prev_d      = prev_q;
    brk_d       = brk_q;
    best_d      = best_q;
    best_cap_d  = best_cap_q;
    best_idx_d  = best_idx_q;
    rd_vld_d    = issue;
    out_valid_d = out_valid_q;
    out_share_d = out_share_q;
    out_idx_d   = out_idx_q;
    out_imp_d   = out_imp_q;
    out_last_d  = out_last_q;
    sh_we       = 1'b0;
    sh_wd       = best_cap_q;
    div_start   = 1'b0;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (!func_i) begin
            total_d = amount_i;
            cnt_d   = '0;
          end else begin
            if (cap_we) begin
              cnt_d = cnt_q + 1'b1;
            end
            if (last_entry_i) begin
              n_d         = cap_we ? CntW'(cnt_q + 1'b1) : cnt_q;
              cnt_d       = '0;
              i_d         = '0;
              k_d         = '0;
              rem_d       = total_q;
              phase_b_d   = 1'b0;
              have_prev_d = 1'b0;
              found_d     = 1'b0;
              state_d     = StScan;
            end
          end
        end
      end
      StScan: begin
        if (issue) begin
          k_d = k_q + 1'b1;
        end
        if (rd_vld_q && elig && (!found_q || key_sel < best_q)) begin
          found_d    = 1'b1;
          best_d     = key_sel;
          best_cap_d = cap_rd_q;
          best_idx_d = rd_idx_q;
        end
        if (!issue && !rd_vld_q) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        if (div_res.done) begin
          ceil_d  = div_res.quo + AmtW'(div_res.rem_nz);
          state_d = StDec;
        end
      end
      StDec: begin
        k_d     = '0;
        found_d = 1'b0;
        state_d = StScan;
        if (!phase_b_q) begin
          if (best_cap_q < ceil_q) begin
            sh_we       = 1'b1;
            rem_d       = rem_q - best_cap_q;
            i_d         = i_q + 1'b1;
            prev_d      = best_q;
            have_prev_d = 1'b1;
            if (CntW'(i_q + 1'b1) == n_q) begin
              if (rem_d != '0) begin
                out_valid_d = 1'b1;
                out_share_d = '0;
                out_idx_d   = '0;
                out_imp_d   = 1'b1;
                out_last_d  = 1'b1;
                state_d     = StHold;
              end else begin
                state_d = StOrd;
              end
            end
          end else begin
            phase_b_d   = 1'b1;
            brk_d       = best_q;
            have_prev_d = 1'b0;
          end
        end else begin
          sh_we       = 1'b1;
          sh_wd       = ceil_q;
          rem_d       = rem_q - ceil_q;
          i_d         = i_q + 1'b1;
          prev_d      = best_q;
          have_prev_d = 1'b1;
          if (CntW'(i_q + 1'b1) == n_q) begin
            state_d = StOrd;
          end
        end
      end
      StOrd: begin
        state_d = StOwt;
      end
      StOwt: begin
        out_valid_d = 1'b1;
        out_share_d = share_rd_q;
        out_idx_d   = k_q[IdxW-1:0];
        out_imp_d   = 1'b0;
        out_last_d  = CntW'(k_q + 1'b1) == n_q;
        state_d     = StHold;
      end
      StHold: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = StLoad;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = StOrd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      rem_q       <= '0;
      total_q     <= '0;
      phase_b_q   <= 1'b0;
      have_prev_q <= 1'b0;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      k_q         <= k_d;
      rem_q       <= rem_d;
      total_q     <= total_d;
      phase_b_q   <= phase_b_d;
      have_prev_q <= have_prev_d;
      found_q     <= found_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ceil_q      <= ceil_d;
    prev_q      <= prev_d;
    brk_q       <= brk_d;
    best_q      <= best_d;
    best_cap_q  <= best_cap_d;
    best_idx_q  <= best_idx_d;
    out_share_q <= out_share_d;
    out_idx_q   <= out_idx_d;
    out_imp_q   <= out_imp_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign share_o        = out_share_q;
  assign person_index_o = out_idx_q;
  assign impossible_o   = out_imp_q;
  assign last_result_o  = out_last_q;
endmodule

FILE: src/mmfs_div.sv
// Bit-serial restoring divider of an amount by a participant count.
module mmfs_div import mmfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  amt_t     num_i,
  input  cnt_t     den_i,
  output div_res_t res_o
);
  localparam int StepW = $clog2(AmtW);

  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  amt_t             quo_q, quo_d;
  cnt_t             rem_q, rem_d;
  cnt_t             den_q, den_d;
  logic             done_q, done_d;
  logic [CntW:0]    trial;
  logic             fits;

  assign trial = {rem_q, quo_q[AmtW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = fits ? CntW'(trial - {1'b0, den_q}) : trial[CntW-1:0];
      quo_d  = {quo_q[AmtW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(AmtW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign res_o.done   = done_q;
  assign res_o.quo    = quo_q;
  assign res_o.rem_nz = rem_q != '0;
endmodule

FILE: tb/max_min_fair_share_allocator_tb.sv
// Testbench for the max-min fair share allocator: directed table plus random cases.
`timescale 1ns / 100ps

module max_min_fair_share_allocator_tb import mmfs_pkg::*; ();

  localparam int HoldCycles = 8000;

  typedef struct {
    amt_t share;
    idx_t person;
    logic impossible;
    logic last;
  } alloc_t;

  typedef struct {
    logic func;
    amt_t amount;
    logic last_entry;
    logic typed;
    amt_t share;
    logic impossible;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic [31:0] amount_i = '0;
  logic last_entry_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] share_o;
  logic [5:0] person_index_o;
  logic impossible_o;
  logic last_result_o;

  max_min_fair_share_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .amount_i, .last_entry_i,
    .out_valid_o, .out_ready_i, .share_o, .person_index_o, .impossible_o, .last_result_o
  );

  always #5 clk_i = ~clk_i;

  alloc_t alloc_q[$];
  amt_t cap_mem[MaxPeople];
  amt_t total_amt = '0;
  int cap_cnt = 0;
  int mismatches = 0;
  bit failed = 1'b0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int sent = 0;

  function automatic amt_t ceil_share(amt_t num, int den);
    amt_t q;
    q = num / amt_t'(den);
    return q + ((num % amt_t'(den)) != 0);
  endfunction

  function automatic bit ahead(int a, int b, bit desc);
    if (cap_mem[a] != cap_mem[b]) return desc ? cap_mem[a] > cap_mem[b] : cap_mem[a] < cap_mem[b];
    return a < b;
  endfunction

  function automatic void allocate(logic f, amt_t a, logic l);
    int n, i, j, k, key;
    int ord[MaxPeople];
    amt_t share_by_idx[MaxPeople];
    amt_t rem, s;
    alloc_t r;
    if (!f) begin
      total_amt = a;
      cap_cnt = 0;
      return;
    end
    if (cap_cnt < MaxPeople) begin
      cap_mem[cap_cnt] = a;
      cap_cnt++;
    end
    if (!l) return;
    n = cap_cnt;
    cap_cnt = 0;
    for (i = 0; i < n; i++) ord[i] = i;
    for (i = 1; i < n; i++) begin
      key = ord[i];
      j = i;
      while (j > 0 && ahead(key, ord[j-1], 1'b0)) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    rem = total_amt;
    for (i = 0; i < n; i++) begin
      if (cap_mem[ord[i]] >= ceil_share(rem, n - i)) break;
      share_by_idx[ord[i]] = cap_mem[ord[i]];
      rem -= cap_mem[ord[i]];
    end
    if (i == n && rem != 0) begin
      r = '{share: '0, person: '0, impossible: 1'b1, last: 1'b1};
      alloc_q.push_back(r);
      return;
    end
    for (k = i + 1; k < n; k++) begin
      key = ord[k];
      j = k;
      while (j > i && ahead(key, ord[j-1], 1'b1)) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = key;
    end
    for (; i < n; i++) begin
      s = ceil_share(rem, n - i);
      share_by_idx[ord[i]] = s;
      rem -= s;
    end
    for (i = 0; i < n; i++) begin
      r = '{share: share_by_idx[i], person: idx_t'(i), impossible: 1'b0, last: i + 1 == n};
      alloc_q.push_back(r);
    end
  endfunction

  task automatic offer(logic f, amt_t a, logic l);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    amount_i <= a;
    last_entry_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    allocate(f, a, l);
    sent++;
  endtask

  task automatic offer_typed(stim_row_t row);
    int base;
    alloc_t r;
    base = alloc_q.size();
    offer(row.func, row.amount, row.last_entry);
    if (row.typed) begin
      while (alloc_q.size() > base) void'(alloc_q.pop_back());
      r = '{share: row.share, person: '0, impossible: row.impossible, last: 1'b1};
      alloc_q.push_back(r);
    end
  endtask

  task automatic offer_case(bit with_start, int n);
    amt_t c, sum;
    int mode;
    mode = $urandom_range(0, 2);
    sum = '0;
    if (with_start) begin
      case ($urandom_range(0, 3))
        0: c = $urandom;
        1: c = $urandom_range(0, 40);
        default: c = amt_t'($urandom_range(0, 50 * n));
      endcase
      offer(1'b0, mode == 1 ? amt_t'($urandom) : c, 1'($urandom));
    end
    for (int i = 0; i < n; i++) begin
      c = (mode == 0) ? amt_t'($urandom_range(0, 100)) : amt_t'($urandom);
      if ($urandom_range(0, 7) == 0) c = (mode == 2) ? c : amt_t'($urandom_range(0, 3));
      offer(1'b1, c, i == n - 1);
    end
  endtask

  stim_row_t table_rows[] = '{
    '{1'b1, 32'd5, 1'b1, 1'b1, 32'd0, 1'b0},
    '{1'b0, 32'd10, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd1, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd2, 1'b1, 1'b1, 32'd0, 1'b1},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'd10, 1'b1, 1'b0, '0, 1'b0},
    '{1'b1, 32'd3, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd3, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd3, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd3, 1'b1, 1'b0, '0, 1'b0},
    '{1'b0, 32'd7, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd1, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd100, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd5, 1'b1, 1'b0, '0, 1'b0},
    '{1'b1, 32'd2, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd9, 1'b1, 1'b0, '0, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd0, 1'b1, 1'b1, 32'd0, 1'b1},
    '{1'b0, 32'd0, 1'b1, 1'b0, '0, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0},
    '{1'b1, 32'd0, 1'b1, 1'b0, '0, 1'b0}
  };

  always @(posedge clk_i) begin : receiver
    static int stall = 0;
    alloc_t e;
    if (out_valid_o && out_ready_i) begin
      if (alloc_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result share=%h idx=%0d", share_o, person_index_o);
      end else begin
        e = alloc_q.pop_front();
        if (share_o !== e.share || person_index_o !== e.person ||
            impossible_o !== e.impossible || last_result_o !== e.last) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp share=%h idx=%0d imp=%b last=%b got share=%h idx=%0d imp=%b last=%b",
                     e.share, e.person, e.impossible, e.last,
                     share_o, person_index_o, impossible_o, last_result_o);
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      stall = HoldCycles;
    end else if (stall == 0 && idle_en && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 17);
    end
    if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("max_min_fair_share_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i]) offer_typed(table_rows[i]);
    offer(1'b0, 32'd1000, 1'b0);
    for (int i = 0; i < 70; i++) offer(1'b1, amt_t'($urandom_range(1, 60)), i == 69);
    hold_req = 1'b1;
    offer_case(1'b1, 3);
    offer_case(1'b1, 2);
    offer_case(1'b1, 1);
    in_valid_i <= 1'b0;
    wait (alloc_q.size() == 0);
    @(posedge clk_i);
    while (sent < 125) begin
      if (sent > 110) idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0: offer_case(1'b0, $urandom_range(1, 4));
        1: begin
          offer(1'b0, $urandom, 1'b0);
          offer_case(1'b1, $urandom_range(1, 4));
        end
        2: offer_case(1'b1, $urandom_range(9, MaxPeople));
        default: offer_case(1'b1, $urandom_range(1, 8));
      endcase
    end
    in_valid_i <= 1'b0;
    wait (alloc_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && alloc_q.size() == 0) begin
      $display("max_min_fair_share_allocator_tb: PASS");
    end else begin
      $display("max_min_fair_share_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
